// ----- design/lfps_pkg.sv -----
// Shared types, constants and microcode fields for the line follower steering block.
`timescale 1ns / 1ps

package lfps_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Fixed entry points of the microprogram.
    localparam step_t STEP_LOAD = 4'd0;
    localparam step_t STEP_EMIT = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_ERR,
        OP_MAC_P,
        OP_MAC_I,
        OP_MAC_D,
        OP_CORR,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_LOST
    } jump_t;

    // One microcode control word.
    typedef struct packed {
        op_t   op;
        logic  wait_in;
        logic  wait_out;
        jump_t jump;
        step_t target;
    } ctrl_t;

    // Status from the datapath that the sequencer branches and waits on.
    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic lost;
    } seq_status_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_BASE_SPEED = 3'd3;
    localparam logic [2:0] REG_SRCH_SPEED = 3'd4;
    localparam logic [2:0] REG_INT_LIMIT  = 3'd5;
    localparam logic [2:0] REG_CORR_LIMIT = 3'd6;

    // Configuration reset values.
    localparam logic [11:0] GAIN_P_RST     = 12'd486;
    localparam logic [11:0] GAIN_I_RST     = 12'd0;
    localparam logic [11:0] GAIN_D_RST     = 12'd1920;
    localparam logic [6:0]  BASE_SPEED_RST = 7'd23;
    localparam logic [6:0]  SRCH_SPEED_RST = 7'd25;
    localparam logic [6:0]  INT_LIMIT_RST  = 7'd20;
    localparam logic [6:0]  CORR_LIMIT_RST = 7'd20;

    localparam logic [6:0] SPEED_MAX = 7'd100;

    // Last seen side of the line.
    localparam logic [1:0] DIR_UNKNOWN = 2'b00;
    localparam logic [1:0] DIR_RIGHT   = 2'b01;
    localparam logic [1:0] DIR_LEFT    = 2'b11;

    // Sensor weights, bit 0 (rightmost) first.
    localparam logic signed [3:0] SENSOR_WEIGHT [8] = '{
        4'sd5, 4'sd4, 4'sd2, 4'sd1, -4'sd1, -4'sd2, -4'sd4, -4'sd5
    };

endpackage

// ----- design/lfps_seq.sv -----
// Microcode sequencer: step counter and control store for the steering datapath.
`timescale 1ns / 1ps

module lfps_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lfps_pkg::seq_status_t     status,
    output lfps_pkg::ctrl_t           ctrl
);
    import lfps_pkg::*;

    step_t step_reg;
    step_t step_next;

    // Control store. The line-seen path runs every step; a lost line jumps
    // from the first divide step straight to the output step.
    always_comb
    begin
        ctrl = '{op: OP_NOP, wait_in: 1'b0, wait_out: 1'b0, jump: JMP_ALWAYS,
                 target: STEP_LOAD};
        case (step_reg)
            4'd0:
            begin
                ctrl.op      = OP_LOAD;
                ctrl.wait_in = 1'b1;
                ctrl.jump    = JMP_NEXT;
            end
            4'd1:
            begin
                ctrl.op     = OP_DIV;
                ctrl.jump   = JMP_IF_LOST;
                ctrl.target = STEP_EMIT;
            end
            4'd2, 4'd3, 4'd4:
            begin
                ctrl.op   = OP_DIV;
                ctrl.jump = JMP_NEXT;
            end
            4'd5:
            begin
                ctrl.op   = OP_ERR;
                ctrl.jump = JMP_NEXT;
            end
            4'd6:
            begin
                ctrl.op   = OP_MAC_P;
                ctrl.jump = JMP_NEXT;
            end
            4'd7:
            begin
                ctrl.op   = OP_MAC_I;
                ctrl.jump = JMP_NEXT;
            end
            4'd8:
            begin
                ctrl.op   = OP_MAC_D;
                ctrl.jump = JMP_NEXT;
            end
            4'd9:
            begin
                ctrl.op   = OP_CORR;
                ctrl.jump = JMP_NEXT;
            end
            4'd10:
            begin
                ctrl.op       = OP_EMIT;
                ctrl.wait_out = 1'b1;
                ctrl.jump     = JMP_ALWAYS;
                ctrl.target   = STEP_LOAD;
            end
            default:
            begin
                ctrl.op     = OP_NOP;
                ctrl.jump   = JMP_ALWAYS;
                ctrl.target = STEP_LOAD;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (!(ctrl.wait_in && !status.in_fire) && !(ctrl.wait_out && !status.out_free))
        begin
            case (ctrl.jump)
                JMP_NEXT:    step_next = step_reg + step_t'(1);
                JMP_ALWAYS:  step_next = ctrl.target;
                JMP_IF_LOST: step_next = status.lost ? ctrl.target : step_reg + step_t'(1);
                default:     step_next = STEP_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- design/line_follow_pid_steering.sv -----
// Line follower steering: weighted sensor error, positional PID and wheel speed output.
`timescale 1ns / 1ps

// An item is one 8-bit sensor sample; each item yields one pair of wheel speeds. A small
// microprogram runs the work: with the line in sight an item passes from acceptance to
// the output register through one load step, four restoring divide steps for the
// average, one step for the integral and error update, three multiply-accumulate steps
// through the single 13x9 multiplier, one correction step and one output step; with the
// line lost it goes from the first divide step straight to the output step. The next
// item is accepted only in the load step after the output step, so items never overlap,
// and the output step waits while the output register is held by a stalled receiver.
// A finished result waits in the output register without blocking the next item until
// the output step of that next item. Configuration writes are taken only while no item
// is being worked on; a write offered in the load step holds off an input item meanwhile.

module line_follow_pid_steering (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        line_sensors,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [7:0] right_speed,
    output logic signed [7:0] left_speed,
    output logic              line_lost,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [11:0]       cfg_data
);
    import lfps_pkg::*;

    function automatic logic signed [13:0] clamp_sym(input logic signed [13:0] v,
                                                     input logic signed [13:0] lim);
        logic signed [13:0] r;
        r = v;
        if (v > lim)
        begin
            r = lim;
        end
        else if (v < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    ctrl_t       ctrl;
    seq_status_t status;

    // Configuration registers.
    logic [11:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [6:0]  base_speed_reg, search_speed_reg, integral_limit_reg, correction_limit_reg;

    // Controller state.
    logic signed [7:0] error_sum_reg, error_sum_next;
    logic signed [3:0] previous_error_reg;
    logic [1:0]        last_direction_reg, last_direction_next;

    // Work registers.
    logic [3:0]         div_mag_reg, div_quo_reg, count_reg;
    logic [2:0]         div_rem_reg;
    logic               neg_reg, lost_reg;
    logic signed [3:0]  err_reg;
    logic signed [4:0]  diff_reg;
    logic signed [21:0] acc_reg, acc_next;
    logic signed [7:0]  corr_reg, corr_next;

    // Output register.
    logic              out_valid_reg;
    logic signed [7:0] right_speed_reg, left_speed_reg;
    logic              line_lost_reg;

    logic              in_fire, out_free, emit_fire;
    logic signed [4:0] w_sum, w_abs;
    logic [3:0]        w_count;
    logic [3:0]        div_trial;
    logic              div_ge;
    logic signed [3:0] err_val;
    logic signed [8:0] esum_raw, esum_lim;
    logic signed [8:0] mac_opnd;
    logic signed [12:0] mac_gain;
    logic signed [21:0] mac_prod;
    logic signed [21:0] acc_bias;
    logic signed [13:0] corr_q;
    logic signed [8:0] base9, corr9, right_raw, left_raw;
    logic [6:0]        spin_mag;
    logic signed [7:0] spin_pos;
    logic signed [7:0] emit_right, emit_left;

    lfps_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // A configuration write in the load step holds the input off for that cycle.
    assign in_stall  = (ctrl.op != OP_LOAD) || cfg_valid;
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = (ctrl.op == OP_EMIT) && out_free;
    assign status    = '{in_fire: in_fire, out_free: out_free, lost: lost_reg};

    assign cfg_ready = (ctrl.op == OP_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg           <= GAIN_P_RST;
            gain_i_reg           <= GAIN_I_RST;
            gain_d_reg           <= GAIN_D_RST;
            base_speed_reg       <= BASE_SPEED_RST;
            search_speed_reg     <= SRCH_SPEED_RST;
            integral_limit_reg   <= INT_LIMIT_RST;
            correction_limit_reg <= CORR_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN_P:     gain_p_reg           <= cfg_data;
                REG_GAIN_I:     gain_i_reg           <= cfg_data;
                REG_GAIN_D:     gain_d_reg           <= cfg_data;
                REG_BASE_SPEED: base_speed_reg       <= cfg_data[6:0];
                REG_SRCH_SPEED: search_speed_reg     <= cfg_data[6:0];
                REG_INT_LIMIT:  integral_limit_reg   <= cfg_data[6:0];
                REG_CORR_LIMIT: correction_limit_reg <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    // Weighted sum and count of the sensors that see the line.
    always_comb
    begin
        w_sum   = '0;
        w_count = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (line_sensors[i])
            begin
                w_sum   = w_sum + 5'(SENSOR_WEIGHT[i]);
                w_count = w_count + 4'd1;
            end
        end
        w_abs = w_sum[4] ? -w_sum : w_sum;
    end

    // One restoring divide step on the magnitude; the remainder stays below the count.
    assign div_trial = {div_rem_reg, div_mag_reg[3]};
    assign div_ge    = (div_trial >= count_reg);

    assign err_val  = neg_reg ? $signed(4'd0 - div_quo_reg) : $signed(div_quo_reg);
    assign esum_raw = 9'(error_sum_reg) + 9'(err_val);
    assign esum_lim = $signed({2'b00, integral_limit_reg});

    always_comb
    begin
        error_sum_next      = error_sum_reg;
        last_direction_next = last_direction_reg;
        if (ctrl.op == OP_ERR)
        begin
            error_sum_next = 8'(clamp_sym(14'(esum_raw), 14'(esum_lim)));
            if (err_val > 4'sd0)
            begin
                last_direction_next = DIR_RIGHT;
            end
            else if (err_val < 4'sd0)
            begin
                last_direction_next = DIR_LEFT;
            end
        end
    end

    // Shared multiplier: one gain times one error term per step.
    always_comb
    begin
        case (ctrl.op)
            OP_MAC_P:
            begin
                mac_opnd = 9'(err_reg);
                mac_gain = $signed({1'b0, gain_p_reg});
            end
            OP_MAC_I:
            begin
                mac_opnd = 9'(error_sum_reg);
                mac_gain = $signed({1'b0, gain_i_reg});
            end
            default:
            begin
                mac_opnd = 9'(diff_reg);
                mac_gain = $signed({1'b0, gain_d_reg});
            end
        endcase
    end

    assign mac_prod = mac_gain * mac_opnd;
    assign acc_next = ((ctrl.op == OP_MAC_P) ? 22'sd0 : acc_reg) + mac_prod;

    // Division by 256 truncated toward zero, then the correction clamp.
    assign acc_bias  = acc_reg + (acc_reg[21] ? 22'sd255 : 22'sd0);
    assign corr_q    = acc_bias[21:8];
    assign corr_next = 8'(clamp_sym(corr_q, $signed({7'b0000000, correction_limit_reg})));

    assign base9     = $signed({2'b00, base_speed_reg});
    assign corr9     = 9'(corr_reg);
    assign right_raw = base9 + corr9;
    assign left_raw  = base9 - corr9;
    assign spin_mag  = (search_speed_reg > SPEED_MAX) ? SPEED_MAX : search_speed_reg;
    assign spin_pos  = $signed({1'b0, spin_mag});

    always_comb
    begin
        if (lost_reg)
        begin
            // Spin toward the side where the line was last seen; unknown spins left.
            if (last_direction_reg == DIR_RIGHT)
            begin
                emit_right = spin_pos;
                emit_left  = -spin_pos;
            end
            else
            begin
                emit_right = -spin_pos;
                emit_left  = spin_pos;
            end
        end
        else
        begin
            emit_right = 8'(clamp_sym(14'(right_raw), 14'($signed({2'b00, SPEED_MAX}))));
            emit_left  = 8'(clamp_sym(14'(left_raw), 14'($signed({2'b00, SPEED_MAX}))));
        end
    end

    // Work registers carry no reset; each item loads them before use.
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD:
            begin
                div_mag_reg <= w_abs[3:0];
                neg_reg     <= w_sum[4];
                count_reg   <= w_count;
                lost_reg    <= (line_sensors == 8'd0);
                div_rem_reg <= '0;
                div_quo_reg <= '0;
            end
            OP_DIV:
            begin
                div_mag_reg <= {div_mag_reg[2:0], 1'b0};
                div_rem_reg <= div_ge ? 3'(div_trial - count_reg) : div_trial[2:0];
                div_quo_reg <= {div_quo_reg[2:0], div_ge};
            end
            OP_ERR:
            begin
                err_reg  <= err_val;
                diff_reg <= 5'(err_val) - 5'(previous_error_reg);
            end
            OP_MAC_P, OP_MAC_I, OP_MAC_D:
            begin
                acc_reg <= acc_next;
            end
            OP_CORR:
            begin
                corr_reg <= corr_next;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg      <= '0;
            previous_error_reg <= '0;
            last_direction_reg <= DIR_UNKNOWN;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            error_sum_reg      <= error_sum_next;
            last_direction_reg <= last_direction_next;
            if (ctrl.op == OP_ERR)
            begin
                previous_error_reg <= err_val;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            right_speed_reg <= emit_right;
            left_speed_reg  <= emit_left;
            line_lost_reg   <= lost_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign right_speed = right_speed_reg;
    assign left_speed  = left_speed_reg;
    assign line_lost   = line_lost_reg;

`ifndef ASSERT_OFF
    // Once an item is taken, the sequencer is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again right after an item");

    // A search spin always drives the wheels in opposite directions at equal speed.
    a_spin_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_lost) |-> (right_speed == -left_speed))
        else $error("search spin speeds are not symmetric");

    // The integral update leaves the accumulated error inside its clamp.
    a_integral_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_ERR) |=> ((9'(error_sum_reg) <= esum_lim)
                                  && (9'(error_sum_reg) >= -esum_lim)))
        else $error("accumulated error outside its limit");
`endif

endmodule

// ----- tb/line_follow_pid_steering_test.sv -----
// Self-checking testbench for the line follower steering block.
`timescale 1ns / 1ps

module line_follow_pid_steering_test;
    import lfps_pkg::*;

    // Index that names no register; writes to it must change nothing.
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int ITEM_CYCLES = 11;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 130;

    typedef struct {
        logic signed [7:0] right;
        logic signed [7:0] left;
        logic              lost;
    } wheel_cmd_t;

    class wheel_board;
        logic [11:0]       kp, ki, kd;
        logic [6:0]        base, search, ilim, clim;
        logic signed [7:0] err_acc;
        logic signed [3:0] prev_err;
        logic [1:0]        last_side;
        wheel_cmd_t        due_cmds[$];
        int                fails;
        int                seen;
        int                spins;

        function new();
            kp = GAIN_P_RST;
            ki = GAIN_I_RST;
            kd = GAIN_D_RST;
            base = BASE_SPEED_RST;
            search = SRCH_SPEED_RST;
            ilim = INT_LIMIT_RST;
            clim = CORR_LIMIT_RST;
            err_acc = '0;
            prev_err = '0;
            last_side = DIR_UNKNOWN;
            fails = 0;
            seen = 0;
            spins = 0;
        endfunction

        function int limit_sym(int v, int lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void set_reg(logic [2:0] idx, logic [11:0] val);
            case (idx)
                REG_GAIN_P:     kp = val;
                REG_GAIN_I:     ki = val;
                REG_GAIN_D:     kd = val;
                REG_BASE_SPEED: base = val[6:0];
                REG_SRCH_SPEED: search = val[6:0];
                REG_INT_LIMIT:  ilim = val[6:0];
                REG_CORR_LIMIT: clim = val[6:0];
                default: ;
            endcase
        endfunction

        // Works out the wheel command for one accepted sensor sample.
        function void note_sample(logic [7:0] s);
            int         total, hits, e, acc, corr, spd, i;
            wheel_cmd_t w;
            total = 0;
            hits = 0;
            for (i = 0; i < 8; i++) begin
                if (s[i]) begin
                    total += int'(SENSOR_WEIGHT[i]);
                    hits++;
                end
            end
            if (hits == 0) begin
                spd = (int'(search) > int'(SPEED_MAX)) ? int'(SPEED_MAX) : int'(search);
                if (last_side == DIR_RIGHT) begin
                    w.right = 8'(spd);
                    w.left = 8'(-spd);
                end else begin
                    w.right = 8'(-spd);
                    w.left = 8'(spd);
                end
                w.lost = 1'b1;
            end else begin
                e = total / hits;
                if (e > 0)
                    last_side = DIR_RIGHT;
                else if (e < 0)
                    last_side = DIR_LEFT;
                err_acc = 8'(limit_sym(int'(err_acc) + e, int'(ilim)));
                acc = int'(kp) * e + int'(ki) * int'(err_acc)
                    + int'(kd) * (e - int'(prev_err));
                prev_err = 4'(e);
                corr = limit_sym(acc / 256, int'(clim));
                w.right = 8'(limit_sym(int'(base) + corr, int'(SPEED_MAX)));
                w.left = 8'(limit_sym(int'(base) - corr, int'(SPEED_MAX)));
                w.lost = 1'b0;
            end
            due_cmds.push_back(w);
        endfunction

        task report(string msg);
            fails++;
            if (fails <= 40)
                $display("MISMATCH: %s", msg);
        endtask

        task check_wheels(logic signed [7:0] right, logic signed [7:0] left, logic lost);
            wheel_cmd_t w;
            seen++;
            if (lost === 1'b1)
                spins++;
            if (due_cmds.size() == 0) begin
                report($sformatf("wheel command %0d with no sample pending", seen));
            end else begin
                w = due_cmds.pop_front();
                if (right !== w.right)
                    report($sformatf("command %0d right_speed %0d, want %0d",
                                     seen, right, w.right));
                if (left !== w.left)
                    report($sformatf("command %0d left_speed %0d, want %0d",
                                     seen, left, w.left));
                if (lost !== w.lost)
                    report($sformatf("command %0d line_lost %b, want %b",
                                     seen, lost, w.lost));
            end
        endtask

        function int waiting();
            return due_cmds.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        line_sensors;
    logic              out_valid;
    logic              out_stall;
    logic signed [7:0] right_speed;
    logic signed [7:0] left_speed;
    logic              line_lost;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [11:0]       cfg_data;

    wheel_board board = new();
    int         samples_sent = 0;
    int         settings_used = 0;
    int         line_pos = 3;

    line_follow_pid_steering u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .line_sensors (line_sensors),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .right_speed  (right_speed),
        .left_speed   (left_speed),
        .line_lost    (line_lost),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [11:0] pick_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 12'd0;
        if (r == 1)
            return 12'hFFF;
        if (r < 5)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, 1023));
    endfunction

    // Speeds and limits, now and then with stray bits above the 7-bit field.
    function automatic logic [11:0] pick_speed();
        int         r;
        logic [6:0] v;
        logic [4:0] junk;
        r = $urandom_range(0, 9);
        junk = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0;
        if (r == 0)
            v = 7'd0;
        else if (r == 1)
            v = SPEED_MAX;
        else if (r == 2)
            v = 7'($urandom_range(101, 127));
        else
            v = 7'($urandom_range(0, 100));
        return {junk, v};
    endfunction

    // Half the samples a line that drifts across the array, the rest lost-line and random samples.
    function automatic logic [7:0] pick_sensors();
        int         r, w, k;
        logic [7:0] s;
        r = $urandom_range(0, 99);
        s = '0;
        if (r < 10)
            return 8'h00;
        if (r < 60) begin
            if (r < 15)
                line_pos = ($urandom_range(0, 1) == 1) ? 7 : 0;
            else
                line_pos = line_pos + $urandom_range(0, 2) - 1;
            if (line_pos < 0)
                line_pos = 0;
            if (line_pos > 7)
                line_pos = 7;
            w = $urandom_range(1, 3);
            for (k = 0; k < w; k++) begin
                if (line_pos + k <= 7)
                    s[line_pos + k] = 1'b1;
            end
            return s;
        end
        return 8'($urandom);
    endfunction

    task automatic send_item(input logic [7:0] s, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        line_sensors <= s;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        board.note_sample(s);
        samples_sent++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_setting(input logic [11:0] gp, input logic [11:0] gi,
                                 input logic [11:0] gd, input logic [11:0] bs,
                                 input logic [11:0] ss, input logic [11:0] il,
                                 input logic [11:0] cl);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_BASE_SPEED, bs);
        write_reg(REG_SRCH_SPEED, ss);
        write_reg(REG_INT_LIMIT, il);
        write_reg(REG_CORR_LIMIT, cl);
        write_reg(REG_UNUSED, 12'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (board.waiting() > 0)
            @(posedge clk);
        repeat (ITEM_CYCLES + 4) @(posedge clk);
    endtask

    // Receiver: stall in random stretches, plus one long hold-off that backs up the block.
    initial
    begin : drain
        int   stall_left, mode_left, rx_mode, r;
        bit   held;
        logic stall_next;
        stall_left = 0;
        mode_left = 0;
        rx_mode = 0;
        held = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                board.check_wheels(right_speed, left_speed, line_lost);
            if (mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 250);
            end else begin
                mode_left--;
            end
            stall_next = 1'b0;
            if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if (!held && board.seen >= 300) begin
                held = 1'b1;
                stall_left = 89;
                stall_next = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (rx_mode == 1 && r < 20) begin
                    stall_next = 1'b1;
                    stall_left = $urandom_range(0, 2);
                end else if (rx_mode == 2 && r < 4) begin
                    stall_next = 1'b1;
                    stall_left = $urandom_range(15, 40);
                end else if (rx_mode == 2 && r < 50) begin
                    stall_next = 1'b1;
                    stall_left = $urandom_range(0, 3);
                end
            end
            out_stall <= stall_next;
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("line_follow_pid_steering_test failed");
        $finish;
    end

    // Lost line with unknown side, then right, zero error, left, and assorted shapes.
    localparam logic [7:0] OPENING [16] = '{
        8'h00, 8'h01, 8'h00, 8'h18, 8'h00, 8'h80, 8'h00, 8'hFF,
        8'h03, 8'h07, 8'h0F, 8'hE0, 8'hC0, 8'h81, 8'h55, 8'hAA
    };
    localparam logic [7:0] SATURATE [8] = '{
        8'h01, 8'h01, 8'h01, 8'h01, 8'h80, 8'h80, 8'h00, 8'h18
    };
    localparam logic [7:0] NULL_GAINS [3] = '{8'h01, 8'h80, 8'h00};

    initial
    begin : stimulus
        int ph, n;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        line_sensors <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first, then everything at its top, then everything at zero.
        foreach (OPENING[k])
            send_item(OPENING[k], pick_gap());
        wait_quiet();
        apply_setting(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        foreach (SATURATE[k])
            send_item(SATURATE[k], pick_gap());
        wait_quiet();
        apply_setting(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        foreach (NULL_GAINS[k])
            send_item(NULL_GAINS[k], pick_gap());
        wait_quiet();

        for (ph = 0; ph < PHASES; ph++) begin
            apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_speed(),
                          pick_speed(), pick_speed(), pick_speed());
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_sensors(), (n % 60 < 12) ? 0 : pick_gap());
            wait_quiet();
        end
        repeat (2 * ITEM_CYCLES) @(posedge clk);

        $display("Covered %0d sensor samples and %0d wheel commands, %0d of them search spins,",
                 samples_sent, board.seen, board.spins);
        $display("across %0d register settings; %0d mismatches.", settings_used, board.fails);
        if (board.fails == 0)
            $display("line_follow_pid_steering_test passed");
        else
            $display("line_follow_pid_steering_test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/lfps_pkg.sv
design/lfps_seq.sv
design/line_follow_pid_steering.sv
tb/line_follow_pid_steering_test.sv
